// File: hdl/windowed_event_rate_meter_top_assert.svh
// Assertion macros for the windowed event rate meter.
// Used by the back-end module; compiled out when SYNTH is set.
`ifndef WINDOWED_EVENT_RATE_METER_TOP_ASSERT_SVH
`define WINDOWED_EVENT_RATE_METER_TOP_ASSERT_SVH
`ifndef SYNTH
`define WER_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("wer assertion failed");
`define WER_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("wer assertion failed");
`else
`define WER_ASSERT(lbl, clk, rst, prop)
`define WER_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: hdl/wer_pkg.sv
// Shared widths, constants and types of the windowed event rate meter.
// No dependencies; imported by every module of the block.
`default_nettype none
package wer_pkg;
  localparam int TIME_W   = 40;
  localparam int COUNT_W  = 32;
  localparam int WIN_W    = 32;
  localparam int RATE_W   = 48;
  localparam int FRAC_W   = 8;
  localparam int US_W     = 20;
  localparam int MUL_W    = COUNT_W + US_W;
  localparam int NUM_W    = MUL_W + FRAC_W;
  localparam int STEP_W   = $clog2(NUM_W);
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [US_W-1:0]    US_PER_SEC   = US_W'(1000000);
  localparam logic [WIN_W-1:0]   WINDOW_RESET = WIN_W'(1000000);
  localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

  // one classified event handed from front to back
  typedef struct packed {
    logic               closed;
    logic [COUNT_W-1:0] total;
    logic [TIME_W-1:0]  ts;
    logic [COUNT_W-1:0] win_count;
    logic [TIME_W-1:0]  elapsed;
  } wer_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_OUT
  } wer_state_t;
endpackage
`default_nettype wire

// File: hdl/wer_front.sv
// Front end: accepts events, keeps counts and window start, flags window closure.
// Depends on wer_pkg.
`default_nettype none
module wer_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [wer_pkg::WIN_W-1:0]    cfg_wdata,
  input  logic                         s_valid,
  output logic                         s_ready,
  input  logic [wer_pkg::TIME_W-1:0]   s_ts,
  output logic                         cmd_valid,
  output wer_pkg::wer_cmd_t            cmd,
  input  logic                         cmd_ready
);
  import wer_pkg::*;

  logic [WIN_W-1:0]   window_us;
  logic [COUNT_W-1:0] event_total;
  logic [COUNT_W-1:0] window_events;
  logic [TIME_W-1:0]  window_start;

  logic [COUNT_W-1:0] total_inc;
  logic [COUNT_W-1:0] win_inc;
  logic [TIME_W-1:0]  elapsed;
  logic               closed;
  logic               push;

  assign s_ready   = cmd_ready;
  assign cmd_valid = s_valid;
  assign push      = s_valid && cmd_ready;

  always_comb begin
    total_inc = (event_total == COUNT_MAX) ? event_total : event_total + 1'b1;
    win_inc   = (window_events == COUNT_MAX) ? window_events : window_events + 1'b1;
    // time running backwards counts as no elapsed time
    elapsed   = (s_ts >= window_start) ? s_ts - window_start : '0;
    closed    = elapsed >= TIME_W'(window_us);

    cmd.closed    = closed;
    cmd.total     = total_inc;
    cmd.ts        = s_ts;
    cmd.win_count = win_inc - 1'b1;
    cmd.elapsed   = elapsed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_us     <= WINDOW_RESET;
      event_total   <= '0;
      window_events <= '0;
      window_start  <= '0;
    end else begin
      if (cfg_we) begin
        window_us <= cfg_wdata;
      end
      if (push) begin
        event_total <= total_inc;
        if (closed) begin
          window_start  <= s_ts;
          window_events <= '0;
        end else begin
          window_events <= win_inc;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: hdl/wer_queue.sv
// Short command queue between front and back end.
// Depends on wer_pkg.
`default_nettype none
module wer_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  wer_pkg::wer_cmd_t  in_cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output wer_pkg::wer_cmd_t  out_cmd
);
  import wer_pkg::*;

  wer_cmd_t          slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign in_ready  = count != QCNT_W'(QDEPTH);
  assign out_valid = count != '0;
  assign out_cmd   = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// File: hdl/wer_back.sv
// Back end: computes both rates with one shared bit-serial divider, holds
// the rate registers and drives the result register. Depends on wer_pkg.
`default_nettype none
`include "windowed_event_rate_meter_top_assert.svh"
module wer_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  wer_pkg::wer_cmd_t             q_cmd,
  output logic                          m_valid,
  input  logic                          m_ready,
  output logic                          m_closed,
  output logic [wer_pkg::COUNT_W-1:0]   m_total,
  output logic [wer_pkg::RATE_W-1:0]    m_trate,
  output logic [wer_pkg::RATE_W-1:0]    m_rrate
);
  import wer_pkg::*;

  wer_state_t         state;
  wer_state_t         state_next;
  wer_cmd_t           cur;
  logic               sel;        // 0: total rate, 1: recent rate
  logic [NUM_W-1:0]   num;
  logic [TIME_W-1:0]  den;
  logic [TIME_W-1:0]  rem;
  logic [NUM_W-1:0]   quo;
  logic [STEP_W-1:0]  step;
  logic               num_zero;
  logic [RATE_W-1:0]  rate_t;
  logic [RATE_W-1:0]  rate_r;

  logic [COUNT_W-1:0] count_sel;
  logic [TIME_W-1:0]  den_sel;
  logic [MUL_W-1:0]   prod;
  logic [TIME_W:0]    rem_sh;
  logic               rem_ge;
  logic [TIME_W:0]    rem_new;
  logic [NUM_W-1:0]   quo_new;
  logic [RATE_W-1:0]  rate_res;
  logic               out_load;

  assign q_ready  = state == S_IDLE;
  assign out_load = (state == S_OUT) && (!m_valid || m_ready);

  always_comb begin
    count_sel = sel ? cur.win_count : cur.total;
    den_sel   = sel ? cur.elapsed : cur.ts;
    prod      = MUL_W'(count_sel) * MUL_W'(US_PER_SEC);
    rem_sh    = {rem, num[NUM_W-1]};
    rem_ge    = rem_sh >= {1'b0, den};
    rem_new   = rem_ge ? rem_sh - {1'b0, den} : rem_sh;
    quo_new   = {quo[NUM_W-2:0], rem_ge};
    // zero numerator gives zero even over a zero divisor; a quotient too wide for RATE_W saturates
    if (num_zero) begin
      rate_res = '0;
    end else if (|quo_new[NUM_W-1:RATE_W]) begin
      rate_res = '1;
    end else begin
      rate_res = quo_new[RATE_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          state_next = q_cmd.closed ? S_MUL : S_OUT;
        end
      end
      S_MUL: state_next = S_DIV;
      S_DIV: begin
        if (step == '0) begin
          state_next = sel ? S_OUT : S_MUL;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          cur <= q_cmd;
          sel <= 1'b0;
        end
      end
      S_MUL: begin
        num      <= NUM_W'(prod) << FRAC_W;
        den      <= den_sel;
        rem      <= '0;
        quo      <= '0;
        step     <= STEP_W'(NUM_W - 1);
        num_zero <= count_sel == '0;
      end
      S_DIV: begin
        num  <= num << 1;
        rem  <= rem_new[TIME_W-1:0];
        quo  <= quo_new;
        step <= step - 1'b1;
        if (step == '0) begin
          sel <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_t <= '0;
      rate_r <= '0;
    end else if (state == S_DIV && step == '0) begin
      if (sel) begin
        rate_r <= rate_res;
      end else begin
        rate_t <= rate_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (out_load) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_closed <= cur.closed;
      m_total  <= cur.total;
      m_trate  <= rate_t;
      m_rrate  <= rate_r;
    end
  end

  `WER_ASSERT(a_div_only_closed, clk, rst, (state == S_DIV) |-> cur.closed)
  `WER_ASSERT(a_rem_below_den, clk, rst, (state == S_DIV && den != '0) |-> (rem < den))
  `WER_ASSERT(a_second_div_ends, clk, rst, (state == S_DIV && step == '0 && sel) |=> (state == S_OUT))
endmodule
`default_nettype wire

// File: hdl/windowed_event_rate_meter_top.sv
// Top level of the windowed event rate meter.
// Depends on wer_pkg, wer_front, wer_queue and wer_back.
`default_nettype none
// An event that does not close a window passes front end, queue and back end
// and reaches the result register through a queue slot and the back end's
// idle and output states. An event that closes the window also passes through
// the shared divider in the back end, which produces one quotient bit per
// cycle, first for the total rate and then for the recent rate. The front
// end keeps counting and takes up to two more events into the queue while
// the divider is busy. A result waiting on m_axis_tready holds the back end
// in its output state, and the input stalls once the queue is full.
module windowed_event_rate_meter_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [wer_pkg::WIN_W-1:0]      cfg_wdata,      // window_us
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [wer_pkg::TIME_W-1:0]     s_axis_tdata,   // timestamp_us
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // total_count [31:0], rate since reset [79:32], recent_rate_fp [127:80]
  output logic [127:0]                   m_axis_tdata,
  output logic [0:0]                     m_axis_tuser    // window_closed
);
  import wer_pkg::*;

  logic               f_valid;
  logic               f_ready;
  wer_cmd_t           f_cmd;
  logic               b_valid;
  logic               b_ready;
  wer_cmd_t           b_cmd;
  logic               m_closed;
  logic [COUNT_W-1:0] m_total;
  logic [RATE_W-1:0]  m_trate;
  logic [RATE_W-1:0]  m_rrate;

  wer_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_valid   (s_axis_tvalid),
    .s_ready   (s_axis_tready),
    .s_ts      (s_axis_tdata),
    .cmd_valid (f_valid),
    .cmd       (f_cmd),
    .cmd_ready (f_ready)
  );

  wer_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_cmd    (f_cmd),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_cmd   (b_cmd)
  );

  wer_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (b_valid),
    .q_ready  (b_ready),
    .q_cmd    (b_cmd),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .m_closed (m_closed),
    .m_total  (m_total),
    .m_trate  (m_trate),
    .m_rrate  (m_rrate)
  );

  assign m_axis_tdata = {m_rrate, m_trate, m_total};
  assign m_axis_tuser = m_closed;
endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for windowed_event_rate_meter_top: directed table, then random phases.
// Depends on wer_pkg and the meter RTL; results are checked against an in-bench rate predictor.
module testbench;
  import wer_pkg::*;

  localparam int RANDOM_EVENTS  = 1780;
  localparam int RX_HOLD_CYCLES = 600;
  localparam int END_SLACK      = 16;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int N_ROWS         = 19;
  localparam logic [RATE_W-1:0] RATE_SAT = '1;
  localparam logic [TIME_W-1:0] TIME_TOP = '1;
  localparam logic [TIME_W-1:0] TIME_MID = TIME_W'(1) << (TIME_W - 1);

  typedef struct packed {
    logic               closed;
    logic [COUNT_W-1:0] count;
    logic [RATE_W-1:0]  overall_rate;
    logic [RATE_W-1:0]  recent_rate;
  } meter_result_t;

  typedef enum logic {ROW_WINDOW, ROW_EVENT} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [TIME_W-1:0] value;   // timestamp, or window length for ROW_WINDOW
    logic              typed;   // result below is the expectation
    meter_result_t     result;
  } stim_row_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [WIN_W-1:0]   cfg_wdata;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [TIME_W-1:0]  s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [127:0]       m_axis_tdata;
  logic [0:0]         m_axis_tuser;

  // predictor state
  logic [WIN_W-1:0]   window_len_us;
  logic [COUNT_W-1:0] events_seen;
  logic [COUNT_W-1:0] events_in_window;
  logic [TIME_W-1:0]  window_open_us;
  logic [RATE_W-1:0]  overall_rate_now;
  logic [RATE_W-1:0]  recent_rate_now;

  meter_result_t pending_results[$];
  int   fail_count  = 0;
  int   cycle_count = 0;
  int   burst_left;
  logic rx_hold_req;

  stim_row_t directed_rows [N_ROWS] = '{
    '{ROW_EVENT,  40'd0,             1'b1, '{1'b0, 32'd1, 48'd0, 48'd0}},
    '{ROW_EVENT,  40'd999999,        1'b1, '{1'b0, 32'd2, 48'd0, 48'd0}},
    '{ROW_EVENT,  40'd1000000,       1'b1, '{1'b1, 32'd3, 48'd768, 48'd512}},
    '{ROW_EVENT,  40'd1000000,       1'b1, '{1'b0, 32'd4, 48'd768, 48'd512}},
    '{ROW_EVENT,  40'd500,           1'b1, '{1'b0, 32'd5, 48'd768, 48'd512}},
    '{ROW_WINDOW, 40'd0,             1'b0, '0},
    '{ROW_EVENT,  40'd0,             1'b1, '{1'b1, 32'd6, RATE_SAT, RATE_SAT}},
    '{ROW_EVENT,  40'd7,             1'b1, '{1'b1, 32'd7, 48'd256000000, 48'd0}},
    '{ROW_EVENT,  TIME_TOP,          1'b0, '0},
    '{ROW_EVENT,  40'h55_5555_5555,  1'b0, '0},
    '{ROW_EVENT,  40'hAA_AAAA_AAAA,  1'b0, '0},
    '{ROW_EVENT,  40'd0,             1'b0, '0},
    '{ROW_WINDOW, 40'h00_FFFF_FFFF,  1'b0, '0},
    '{ROW_EVENT,  40'h00_FFFF_FFFE,  1'b0, '0},
    '{ROW_EVENT,  40'h00_FFFF_FFFF,  1'b0, '0},
    '{ROW_WINDOW, 40'd1,             1'b0, '0},
    '{ROW_EVENT,  40'h00_FFFF_FFFF,  1'b0, '0},
    '{ROW_EVENT,  40'h01_0000_0000,  1'b0, '0},
    '{ROW_EVENT,  40'h01_0000_0001,  1'b0, '0}
  };

  windowed_event_rate_meter_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // floor(count * 1e6 * 2^FRAC / span), saturated; the numerator fits in 60 bits
  function automatic logic [RATE_W-1:0] rate_fp(logic [COUNT_W-1:0] count,
                                                logic [TIME_W-1:0] span_us);
    logic [63:0] num;
    logic [63:0] quo;
    num = (64'(count) * 64'(US_PER_SEC)) << FRAC_W;
    if (span_us == '0) return (num != 64'd0) ? RATE_SAT : '0;
    quo = num / 64'(span_us);
    return (quo > 64'(RATE_SAT)) ? RATE_SAT : quo[RATE_W-1:0];
  endfunction

  function automatic meter_result_t meter_event(logic [TIME_W-1:0] ts);
    logic [TIME_W-1:0] elapsed;
    meter_result_t     r;
    if (events_seen != COUNT_MAX) events_seen = events_seen + 1'b1;
    if (events_in_window != COUNT_MAX) events_in_window = events_in_window + 1'b1;
    // time going backwards counts as no time at all
    elapsed = (ts >= window_open_us) ? ts - window_open_us : '0;
    r.closed = 1'b0;
    if (elapsed >= TIME_W'(window_len_us)) begin
      overall_rate_now = rate_fp(events_seen, ts);
      recent_rate_now  = rate_fp(events_in_window - 1'b1, elapsed);
      window_open_us   = ts;
      events_in_window = '0;
      r.closed         = 1'b1;
    end
    r.count        = events_seen;
    r.overall_rate = overall_rate_now;
    r.recent_rate  = recent_rate_now;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // sender: bursts of random length with random gaps in between
  task automatic offer_event(input logic [TIME_W-1:0] ts, input logic typed,
                             input meter_result_t given);
    int            gap;
    meter_result_t predicted;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ts;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predicted = meter_event(ts);
    pending_results.push_back(typed ? given : predicted);
  endtask

  // window length changes only with the meter drained
  task automatic write_window(input logic [WIN_W-1:0] len_us);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= len_us;
    @(posedge clk);
    cfg_we        <= 1'b0;
    window_len_us  = len_us;
  endtask

  // receiver: stall pattern changes after each random span, plus one long hold
  initial begin : rx_side
    int   mode;
    int   span;
    logic hold_taken;
    hold_taken = 1'b0;
    forever begin
      if (rx_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(8, 64);
        repeat (span) begin
          case (mode)
            0: begin
              m_axis_tready <= 1'b1;
            end
            1: begin
              m_axis_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
              m_axis_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
              m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
          endcase
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    meter_result_t got;
    meter_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser[0], m_axis_tdata[31:0], m_axis_tdata[79:32], m_axis_tdata[127:80]};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual closed=%0d count=%0d",
                 $time, got.closed, got.count);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("window_closed", 64'(want.closed), 64'(got.closed));
        check_field("total_count", 64'(want.count), 64'(got.count));
        check_field("overall_rate_fp", 64'(want.overall_rate), 64'(got.overall_rate));
        check_field("recent_rate_fp", 64'(want.recent_rate), 64'(got.recent_rate));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int                i;
    int                sent;
    int                phase_len;
    int                pick;
    logic              first_phase;
    logic [TIME_W-1:0] now_us;
    logic [TIME_W-1:0] ts;
    logic [TIME_W-1:0] span;
    logic [WIN_W-1:0]  len;

    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    rx_hold_req    = 1'b0;
    burst_left     = 0;

    window_len_us    = WINDOW_RESET;
    events_seen      = '0;
    events_in_window = '0;
    window_open_us   = '0;
    overall_rate_now = '0;
    recent_rate_now  = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < N_ROWS; i++) begin
      if (directed_rows[i].kind == ROW_WINDOW)
        write_window(directed_rows[i].value[WIN_W-1:0]);
      else
        offer_event(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].result);
    end

    now_us      = window_open_us;
    sent        = 0;
    first_phase = 1'b1;
    while (sent < RANDOM_EVENTS) begin
      pick = $urandom_range(0, 9);
      if (first_phase)
        len = 50;
      else if (now_us > TIME_MID || pick == 0)
        len = '0;
      else if (pick == 1)
        len = '1;
      else if (pick == 2)
        len = $urandom;
      else if (pick == 3)
        len = 1;
      else
        len = $urandom_range(2, 5000);
      write_window(len);

      if (len == '0) begin
        // every event closes; scatter timestamps over the full range, end low
        phase_len = $urandom_range(20, 60);
        for (i = 0; i < phase_len; i++) begin
          if (i == phase_len - 1)
            ts = TIME_W'($urandom_range(0, 1000));
          else if ($urandom_range(0, 1) == 1)
            ts = TIME_W'({$urandom, $urandom});
          else
            ts = now_us + $urandom_range(0, 100);
          offer_event(ts, 1'b0, '0);
          now_us = ts;
          sent++;
        end
      end else begin
        phase_len = $urandom_range(40, 160);
        for (i = 0; i < phase_len; i++) begin
          if (first_phase && i == 5) rx_hold_req = 1'b1;
          pick = $urandom_range(0, 31);
          if (pick < 2 && now_us != '0) begin
            // stale timestamp, behind the current time
            ts = TIME_W'({$urandom, $urandom}) % now_us;
          end else if (pick < 5) begin
            // land on or just before the window boundary
            ts = window_open_us + TIME_W'(len) - TIME_W'($urandom_range(0, 1));
            if (ts < now_us) ts = now_us;
            now_us = ts;
          end else if (pick == 5) begin
            ts = now_us;
          end else begin
            span   = TIME_W'({$urandom, $urandom}) % (TIME_W'(len) / 2 + 1);
            ts     = now_us + span;
            now_us = ts;
          end
          offer_event(ts, 1'b0, '0);
          sent++;
        end
      end
      first_phase = 1'b0;
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (END_SLACK) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// File: windowed_event_rate_meter_top.f
+incdir+hdl
hdl/wer_pkg.sv
hdl/wer_front.sv
hdl/wer_queue.sv
hdl/wer_back.sv
hdl/windowed_event_rate_meter_top.sv
tb/testbench.sv
